// File: hw/rtl/fu_pkg.sv
// Shared types and sizes for the form-urlencoded tokenizer.
package fu_pkg;

   localparam int MAX_RES     = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int RCNT_W      = $clog2(MAX_RES + 1);
   localparam int RIDX_W      = $clog2(MAX_RES);

   typedef struct packed {
      logic [7:0] out_byte;
      logic       in_value;
      logic       pair_end;
   } res_type;

   typedef struct packed {
      logic [RCNT_W-1:0]   count;
      res_type [MAX_RES-1:0] slot;
   } group_type;

endpackage

// File: hw/rtl/fu_if.sv
// Valid/ready channel interfaces for request and response beats.
interface fu_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] raw_byte;

   modport source (output valid, output kind, output raw_byte, input ready);
   modport sink   (input valid, input kind, input raw_byte, output ready);
endinterface

interface fu_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       in_value;
   logic       pair_end;
   logic       last;

   modport source (output valid, output out_byte, output in_value, output pair_end,
                   output last, input ready);
   modport sink   (input valid, input out_byte, input in_value, input pair_end,
                   input last, output ready);
endinterface

// File: hw/rtl/fu_front.sv
// Front end: parses each request beat and builds its group of results.
module fu_front
   import fu_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   fu_req_if.sink       req,
   input  logic         push_ready,
   output logic         push_valid,
   output group_type    push_group
);

   localparam logic [7:0] CHAR_PCT   = 8'h25;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_AMP   = 8'h26;
   localparam logic [7:0] CHAR_EQ    = 8'h3D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [3:0] NIB_NINE   = 4'd9;

   localparam logic [1:0] PC_NONE = 2'd0;
   localparam logic [1:0] PC_PCT  = 2'd1;
   localparam logic [1:0] PC_NIB  = 2'd2;

   logic       vp_ff, vp_in;
   logic       po_ff, po_in;
   logic [1:0] pc_ff, pc_in;
   logic [3:0] nib_ff, nib_in;
   logic       up_ff, up_in;

   logic        fire;
   logic [7:0]  c;
   logic        hex_ok;
   logic        hex_upper;
   logic [3:0]  hex_val;
   logic        do_flush;
   logic        plain;
   logic        extra_ok;
   res_type     extra;
   res_type     flush0;
   res_type     flush1;
   logic [1:0]  nflush;
   logic [7:0]  held_char;

   assign req.ready = push_ready;
   assign fire      = req.valid && req.ready;
   assign c         = req.raw_byte;

   always_comb begin
      hex_ok    = 1'b0;
      hex_upper = 1'b0;
      hex_val   = c[3:0];
      if (c >= 8'h30 && c <= 8'h39) begin
         hex_ok = 1'b1;
      end else if (c >= 8'h61 && c <= 8'h66) begin
         hex_ok  = 1'b1;
         hex_val = c[3:0] + NIB_NINE;
      end else if (c >= 8'h41 && c <= 8'h46) begin
         hex_ok    = 1'b1;
         hex_upper = 1'b1;
         hex_val   = c[3:0] + NIB_NINE;
      end
   end

   always_comb begin
      if (nib_ff <= NIB_NINE) begin
         held_char = {4'h3, nib_ff};
      end else begin
         held_char = {(up_ff ? 4'h4 : 4'h6), nib_ff - NIB_NINE};
      end
   end

   always_comb begin
      vp_in    = vp_ff;
      po_in    = po_ff;
      pc_in    = pc_ff;
      nib_in   = nib_ff;
      up_in    = up_ff;
      do_flush = 1'b0;
      plain    = 1'b0;
      extra_ok = 1'b0;
      extra    = '{out_byte: 8'h00, in_value: vp_ff, pair_end: 1'b0};
      if (req.kind || c == CHAR_AMP) begin
         do_flush = po_ff;
         extra_ok = po_ff;
         extra    = '{out_byte: 8'h00, in_value: 1'b0, pair_end: 1'b1};
         vp_in    = 1'b0;
         po_in    = 1'b0;
         pc_in    = PC_NONE;
         nib_in   = 4'h0;
         up_in    = 1'b0;
      end else begin
         po_in = 1'b1;
         if (c == CHAR_EQ && !vp_ff) begin
            do_flush = 1'b1;
            vp_in    = 1'b1;
            pc_in    = PC_NONE;
            nib_in   = 4'h0;
            up_in    = 1'b0;
         end else begin
            unique case (pc_ff)
               PC_PCT: begin
                  if (hex_ok) begin
                     pc_in  = PC_NIB;
                     nib_in = hex_val;
                     up_in  = hex_upper;
                  end else begin
                     do_flush = 1'b1;
                     plain    = 1'b1;
                  end
               end
               PC_NIB: begin
                  if (hex_ok) begin
                     extra_ok       = 1'b1;
                     extra.out_byte = {nib_ff, hex_val};
                     pc_in          = PC_NONE;
                     nib_in         = 4'h0;
                     up_in          = 1'b0;
                  end else begin
                     do_flush = 1'b1;
                     plain    = 1'b1;
                  end
               end
               default: begin
                  plain = 1'b1;
               end
            endcase
            if (plain) begin
               nib_in = 4'h0;
               up_in  = 1'b0;
               if (c == CHAR_PCT) begin
                  pc_in = PC_PCT;
               end else begin
                  pc_in          = PC_NONE;
                  extra_ok       = 1'b1;
                  extra.out_byte = (c == CHAR_PLUS) ? CHAR_SPACE : c;
               end
            end
         end
      end
   end

   assign flush0 = '{out_byte: CHAR_PCT,  in_value: vp_ff, pair_end: 1'b0};
   assign flush1 = '{out_byte: held_char, in_value: vp_ff, pair_end: 1'b0};

   always_comb begin
      nflush = 2'd0;
      if (do_flush && pc_ff == PC_PCT) begin
         nflush = 2'd1;
      end else if (do_flush && pc_ff == PC_NIB) begin
         nflush = 2'd2;
      end
   end

   always_comb begin
      push_group.slot = '0;
      unique case (nflush)
         2'd1: begin
            push_group.slot[0] = flush0;
            push_group.slot[1] = extra;
         end
         2'd2: begin
            push_group.slot[0] = flush0;
            push_group.slot[1] = flush1;
            push_group.slot[2] = extra;
         end
         default: begin
            push_group.slot[0] = extra;
         end
      endcase
      push_group.count = RCNT_W'(nflush) + RCNT_W'(extra_ok);
   end

   assign push_valid = fire && (push_group.count != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         vp_ff  <= 1'b0;
         po_ff  <= 1'b0;
         pc_ff  <= PC_NONE;
         nib_ff <= 4'h0;
         up_ff  <= 1'b0;
      end else if (fire) begin
         vp_ff  <= vp_in;
         po_ff  <= po_in;
         pc_ff  <= pc_in;
         nib_ff <= nib_in;
         up_ff  <= up_in;
      end
   end

endmodule

// File: hw/rtl/fu_queue.sv
// Short queue of result groups between front and back ends.
module fu_queue
   import fu_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   input  group_type push_group,
   output logic      push_ready,
   input  logic      pop,
   output logic      head_valid,
   output group_type head_group
);

   group_type          mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QFILL_W-1:0] fill_ff, fill_in;
   logic               do_push;
   logic               do_pop;

   assign push_ready = (fill_ff != QFILL_W'(QUEUE_DEPTH));
   assign head_valid = (fill_ff != '0);
   assign head_group = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      fill_in   = fill_ff + QFILL_W'(do_push) - QFILL_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_group;
      end
   end

endmodule

// File: hw/rtl/fu_back.sv
// Back end: sends the results of each queued group one beat at a time.
module fu_back
   import fu_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      head_valid,
   input  group_type head_group,
   output logic      pop,
   fu_rsp_if.source  rsp
);

   logic [RIDX_W-1:0] idx_ff, idx_in;
   logic              is_last;
   logic              fire;
   res_type           cur;

   assign cur     = head_group.slot[idx_ff];
   assign is_last = (RCNT_W'(idx_ff) + RCNT_W'(1)) == head_group.count;
   assign fire    = rsp.valid && rsp.ready;
   assign pop     = fire && is_last;

   assign rsp.valid    = head_valid;
   assign rsp.out_byte = cur.out_byte;
   assign rsp.in_value = cur.in_value;
   assign rsp.pair_end = cur.pair_end;
   assign rsp.last     = is_last;

   always_comb begin
      idx_in = idx_ff;
      if (fire) begin
         idx_in = is_last ? '0 : idx_ff + RIDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

// File: hw/rtl/form_urlencoded_tokenizer_top.sv
// A beat's results (up to three) are registered in the queue before being offered.
// Throughput: one request beat per cycle while the four-group queue has room;
// the response side sends one result per cycle while rsp.ready is high.
// A beat that yields no result only updates the parser state.
// Reset (synchronous) empties the queue and returns the parser to the start of a key.
module form_urlencoded_tokenizer_top
   import fu_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   fu_req_if.sink   req,
   fu_rsp_if.source rsp
);

   logic      push_valid;
   logic      push_ready;
   group_type push_group;
   logic      head_valid;
   group_type head_group;
   logic      pop;

   fu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .push_ready (push_ready),
      .push_valid (push_valid),
      .push_group (push_group)
   );

   fu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_group (push_group),
      .push_ready (push_ready),
      .pop        (pop),
      .head_valid (head_valid),
      .head_group (head_group)
   );

   fu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_group (head_group),
      .pop        (pop),
      .rsp        (rsp)
   );

endmodule

// File: hw/rtl/fu_checker.sv
// Port-level checks on the tokenizer top level, attached by bind.
module fu_checker (
   input logic      clock,
   input logic      reset,
   fu_req_if.sink   req,
   fu_rsp_if.source rsp
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.out_byte)
         && $stable(rsp.pair_end) && $stable(rsp.last))
      else $error("response beat changed while stalled");

   a_pair_end_clean: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.pair_end |-> rsp.out_byte == 8'h00 && !rsp.in_value)
      else $error("pair-end beat carries data");

   a_pair_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.pair_end |-> rsp.last)
      else $error("pair-end beat is not the final result of its item");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp.valid)
      else $error("response offered straight after reset");

   a_req_ready_known: assert property (@(posedge clock) disable iff (reset)
      !$isunknown(req.ready))
      else $error("request ready is unknown");

endmodule

bind form_urlencoded_tokenizer_top fu_checker u_fu_checker (
   .clock (clock),
   .reset (reset),
   .req   (req),
   .rsp   (rsp)
);

// File: dv/fu_tb_pkg.sv
`timescale 1ns / 1ps
// Beat kinds and character codes shared by the tokenizer testbench files.
package fu_tb_pkg;

   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_END  = 1'b1;

   localparam logic [7:0] CH_PCT  = 8'h25;
   localparam logic [7:0] CH_PLUS = 8'h2B;
   localparam logic [7:0] CH_AMP  = 8'h26;
   localparam logic [7:0] CH_EQ   = 8'h3D;
   localparam logic [7:0] CH_SP   = 8'h20;
   localparam logic [7:0] CH_0    = 8'h30;
   localparam logic [7:0] CH_9    = 8'h39;
   localparam logic [7:0] CH_LA   = 8'h61;
   localparam logic [7:0] CH_LF   = 8'h66;
   localparam logic [7:0] CH_UA   = 8'h41;
   localparam logic [7:0] CH_UF   = 8'h46;

endpackage

// File: dv/form_urlencoded_tokenizer_checker.sv
`timescale 1ns / 1ps
// Watches both channels, predicts decoded tokens per request beat and checks responses.
module form_urlencoded_tokenizer_checker
   import fu_pkg::*;
   import fu_tb_pkg::*;
(
   input  logic clock,
   input  logic reset,
   fu_req_if    req_mon,
   fu_rsp_if    rsp_mon,
   output int   fail_count,
   output int   tokens_owed
);

   localparam logic [1:0] ESC_NONE  = 2'd0;
   localparam logic [1:0] ESC_PCT   = 2'd1;
   localparam logic [1:0] ESC_DIGIT = 2'd2;

   typedef struct packed {
      res_type body;
      logic    last;
   } token_type;

   token_type exp_buf [256];
   token_type beat_buf [MAX_RES];
   int        exp_wr = 0;
   int        exp_rd = 0;
   int        beat_n = 0;

   logic       in_val;
   logic       pair_live;
   logic [1:0] esc_cnt;
   logic [3:0] esc_nib;
   logic       esc_up;

   int misses = 0;
   int owed   = 0;

   assign fail_count  = misses;
   assign tokens_owed = owed;

   function automatic int hex_val(input logic [7:0] c);
      if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
      if (c >= CH_LA && c <= CH_LF) return int'(c - CH_LA) + 10;
      if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
      return -1;
   endfunction

   function automatic logic [7:0] held_chr();
      if (esc_nib < 4'd10) return CH_0 + 8'(esc_nib);
      return (esc_up ? CH_UA : CH_LA) + 8'(esc_nib) - 8'd10;
   endfunction

   task automatic put(input logic [7:0] b, input logic iv, input logic pe);
      token_type t;
      t.body.out_byte = b;
      t.body.in_value = iv;
      t.body.pair_end = pe;
      t.last = 1'b0;
      if (beat_n < MAX_RES) begin
         beat_buf[beat_n] = t;
         beat_n++;
      end
   endtask

   // held escape prefix goes out literally
   task automatic drop_escape();
      if (esc_cnt == ESC_PCT) begin
         put(CH_PCT, in_val, 1'b0);
      end else if (esc_cnt == ESC_DIGIT) begin
         put(CH_PCT, in_val, 1'b0);
         put(held_chr(), in_val, 1'b0);
      end
      esc_cnt = ESC_NONE;
      esc_nib = 4'd0;
      esc_up  = 1'b0;
   endtask

   task automatic decode(input logic [7:0] c);
      int v;
      v = hex_val(c);
      if (esc_cnt == ESC_PCT) begin
         if (v >= 0) begin
            esc_nib = v[3:0];
            esc_up  = (c >= CH_UA && c <= CH_UF);
            esc_cnt = ESC_DIGIT;
            return;
         end
         drop_escape();
      end else if (esc_cnt == ESC_DIGIT) begin
         if (v >= 0) begin
            put({esc_nib, v[3:0]}, in_val, 1'b0);
            esc_cnt = ESC_NONE;
            esc_nib = 4'd0;
            esc_up  = 1'b0;
            return;
         end
         drop_escape();
      end else begin
         esc_cnt = ESC_NONE;
      end
      if (c == CH_PCT) begin
         esc_cnt = ESC_PCT;
      end else if (c == CH_PLUS) begin
         put(CH_SP, in_val, 1'b0);
      end else begin
         put(c, in_val, 1'b0);
      end
   endtask

   task automatic close_pair();
      if (pair_live) begin
         drop_escape();
         put(8'd0, 1'b0, 1'b1);
      end
      in_val    = 1'b0;
      pair_live = 1'b0;
      esc_cnt   = ESC_NONE;
      esc_nib   = 4'd0;
      esc_up    = 1'b0;
   endtask

   task automatic predict_tokens(input logic k, input logic [7:0] c);
      beat_n = 0;
      if (k == KIND_END || c == CH_AMP) begin
         close_pair();
      end else begin
         pair_live = 1'b1;
         if (c == CH_EQ && !in_val) begin
            drop_escape();
            in_val = 1'b1;
         end else begin
            decode(c);
         end
      end
      if (beat_n > 0) beat_buf[beat_n-1].last = 1'b1;
      for (int i = 0; i < beat_n; i++) begin
         exp_buf[exp_wr[7:0]] = beat_buf[i];
         exp_wr++;
      end
   endtask

   always @(posedge clock) begin
      token_type want;
      if (reset) begin
         in_val    = 1'b0;
         pair_live = 1'b0;
         esc_cnt   = ESC_NONE;
         esc_nib   = 4'd0;
         esc_up    = 1'b0;
         exp_wr    = 0;
         exp_rd    = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (exp_wr == exp_rd) begin
               $display("%0t: unexpected rsp beat byte=%02h val=%0d end=%0d last=%0d",
                        $time, rsp_mon.out_byte, rsp_mon.in_value, rsp_mon.pair_end,
                        rsp_mon.last);
               misses++;
            end else begin
               want = exp_buf[exp_rd[7:0]];
               exp_rd++;
               if (want.body.out_byte !== rsp_mon.out_byte ||
                   want.body.in_value !== rsp_mon.in_value ||
                   want.body.pair_end !== rsp_mon.pair_end ||
                   want.last !== rsp_mon.last) begin
                  $display("%0t: rsp mismatch exp byte=%02h val=%0d end=%0d last=%0d",
                           $time, want.body.out_byte, want.body.in_value,
                           want.body.pair_end, want.last);
                  $display("%0t:              got byte=%02h val=%0d end=%0d last=%0d",
                           $time, rsp_mon.out_byte, rsp_mon.in_value,
                           rsp_mon.pair_end, rsp_mon.last);
                  misses++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) predict_tokens(req_mon.kind, req_mon.raw_byte);
      end
      owed <= exp_wr - exp_rd;
   end

endmodule

// File: dv/form_urlencoded_tokenizer_top_tb.sv
`timescale 1ns / 1ps
// Stimulus, flow control and verdict for the form-urlencoded tokenizer.
module form_urlencoded_tokenizer_top_tb;
   import fu_tb_pkg::*;

   logic clock;
   logic reset;

   fu_req_if req_if ();
   fu_rsp_if rsp_if ();

   int fail_count;
   int tokens_owed;

   int beats_sent  = 0;
   bit quiet       = 1'b0;
   bit hold_go     = 1'b0;
   bit hold_done   = 1'b0;
   bit hold_active = 1'b0;

   form_urlencoded_tokenizer_top dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   form_urlencoded_tokenizer_checker scoreboard (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_if),
      .rsp_mon     (rsp_if),
      .fail_count  (fail_count),
      .tokens_owed (tokens_owed)
   );

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [7:0] any_hex();
      int r;
      r = $urandom_range(0, 21);
      if (r < 10) return CH_0 + 8'(r);
      if (r < 16) return CH_LA + 8'(r - 10);
      return CH_UA + 8'(r - 16);
   endfunction

   function automatic logic [7:0] plain_char();
      int r;
      r = $urandom_range(0, 61);
      if (r < 10) return CH_0 + 8'(r);
      if (r < 36) return CH_LA + 8'(r - 10);
      return CH_UA + 8'(r - 36);
   endfunction

   task automatic send_beat(input logic k, input logic [7:0] b);
      @(negedge clock);
      if (!quiet && !hold_active && $urandom_range(0, 5) == 0) begin
         req_if.valid = 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req_if.valid    = 1'b1;
      req_if.kind     = k;
      req_if.raw_byte = b;
      do @(posedge clock); while (!req_if.ready);
      beats_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_beat(KIND_BYTE, s[i]);
   endtask

   // response side: random back-pressure, one long hold to fill the queue
   initial begin
      rsp_if.ready = 1'b0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (hold_go && !hold_done) begin
            rsp_if.ready = 1'b0;
            hold_done    = 1'b1;
            hold_active  = 1'b1;
            repeat (80) @(negedge clock);
            hold_active  = 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_if.ready = 1'b0;
            repeat ($urandom_range(0, 18)) @(negedge clock);
         end else begin
            rsp_if.ready = 1'b1;
         end
      end
   end

   initial begin
      int rand_goal;
      int pick;
      reset           = 1'b1;
      req_if.valid    = 1'b0;
      req_if.kind     = KIND_BYTE;
      req_if.raw_byte = 8'd0;
      repeat (12) @(negedge clock);
      reset = 1'b0;

      // empty pairs and empty string
      send_text("&&");
      send_beat(KIND_END, 8'hA5);
      // extreme bytes, a digit-only and a lowercase escape, plus, later equals
      send_beat(KIND_BYTE, 8'h00);
      send_text("%41=%7e+=");
      send_beat(KIND_BYTE, 8'hFF);
      // broken escapes, escape cut by equals and by ampersand
      send_text("&%G%BZ%4%=%c&");
      // escape cut by end of string
      send_text("x%c");
      send_beat(KIND_END, 8'h5A);

      hold_go   = 1'b1;
      rand_goal = beats_sent + 180;
      while (beats_sent < rand_goal) begin
         quiet = (beats_sent > rand_goal - 40);
         pick  = $urandom_range(0, 99);
         if (pick < 30) begin
            send_beat(KIND_BYTE, plain_char());
         end else if (pick < 45) begin
            send_beat(KIND_BYTE, CH_PCT);
            send_beat(KIND_BYTE, any_hex());
            send_beat(KIND_BYTE, any_hex());
         end else if (pick < 52) begin
            send_beat(KIND_BYTE, CH_PLUS);
         end else if (pick < 60) begin
            send_beat(KIND_BYTE, CH_EQ);
         end else if (pick < 70) begin
            send_beat(KIND_BYTE, CH_AMP);
         end else if (pick < 75) begin
            send_beat(KIND_END, 8'($urandom_range(0, 255)));
         end else if (pick < 85) begin
            send_beat(KIND_BYTE, 8'($urandom_range(0, 255)));
         end else if (pick < 92) begin
            send_beat(KIND_BYTE, CH_PCT);
            send_beat(KIND_BYTE, 8'($urandom_range(0, 255)));
         end else begin
            send_beat(KIND_BYTE, CH_PCT);
            send_beat(KIND_BYTE, any_hex());
            send_beat(KIND_BYTE, 8'($urandom_range(0, 255)));
         end
      end
      send_beat(KIND_END, 8'($urandom_range(0, 255)));

      @(negedge clock);
      req_if.valid = 1'b0;
      while (tokens_owed != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      @(negedge clock);
      if (fail_count == 0 && tokens_owed == 0) begin
         $display("form_urlencoded_tokenizer_top_tb: clean");
      end else begin
         $display("form_urlencoded_tokenizer_top_tb: errors");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("form_urlencoded_tokenizer_top_tb: errors");
      $finish;
   end

endmodule

// File: files.f
hw/rtl/fu_pkg.sv
hw/rtl/fu_if.sv
hw/rtl/fu_front.sv
hw/rtl/fu_queue.sv
hw/rtl/fu_back.sv
hw/rtl/form_urlencoded_tokenizer_top.sv
hw/rtl/fu_checker.sv
dv/fu_tb_pkg.sv
dv/form_urlencoded_tokenizer_checker.sv
dv/form_urlencoded_tokenizer_top_tb.sv
